// ----- src/tkmmd_pkg.sv -----
// Package for the top-k merge block: field widths, payload structs and the
// command/status bundles between controller and datapath. No dependencies.
`default_nettype none

package tkmmd_pkg;

  localparam int unsigned ID_W          = 32;
  localparam int unsigned DIST_W        = 32;
  localparam int unsigned KEEP_W        = 6;
  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd32;

  typedef struct packed {
    logic [ID_W-1:0]   item_id;
    logic [DIST_W-1:0] distance;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   entry_id;
    logic [DIST_W-1:0] entry_distance;
    logic              valid_res;
    logic              end_of_list;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic remove;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic lower;
    logic last;
    logic final_entry;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/tkmmd_dp.sv -----
// Datapath: register-held sorted list with per-entry compare, candidate
// registers, keep_count register and result register. Uses tkmmd_pkg.
`default_nettype none

module tkmmd_dp #(
  parameter int unsigned LIST_DEPTH = tkmmd_pkg::DEPTH_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  tkmmd_pkg::in_item_t              in_item,
  input  wire                              cfg_we,
  input  wire [tkmmd_pkg::KEEP_W-1:0]      cfg_wdata,
  input  tkmmd_pkg::cmd_t                  cmd,
  output tkmmd_pkg::sts_t                  sts,
  output logic                             out_strobe,
  output tkmmd_pkg::out_item_t             out_item
);
  import tkmmd_pkg::*;

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  logic [ID_W-1:0]   id_r   [LIST_DEPTH];
  logic [DIST_W-1:0] dist_r [LIST_DEPTH];
  logic [CW-1:0]     count_r;
  logic [ID_W-1:0]   cand_id_r;
  logic [DIST_W-1:0] cand_dist_r;
  logic              cand_last_r;
  logic [KEEP_W-1:0] keep_r;
  logic              out_strobe_r;
  out_item_t         out_item_r;

  logic [CW-1:0]         keep_eff;
  logic [LIST_DEPTH-1:0] valid;
  logic [LIST_DEPTH-1:0] match;
  logic [LIST_DEPTH-1:0] ge_match;
  logic [LIST_DEPTH-1:0] big;
  logic [LIST_DEPTH-1:0] sh;
  logic [DIST_W-1:0]     match_dist;
  logic                  shift_en;
  logic                  ins_ok;
  logic                  ins_en;

  always_comb begin
    if (keep_r == '0) begin
      keep_eff = CW'(1);
    end else if ({1'b0, keep_r} > (KEEP_W + 1)'(LIST_DEPTH)) begin
      keep_eff = CW'(LIST_DEPTH);
    end else begin
      keep_eff = CW'(keep_r);
    end
  end

  always_comb begin
    logic acc;
    acc        = 1'b0;
    match_dist = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      valid[i]    = CW'(i) < count_r;
      match[i]    = valid[i] && (id_r[i] == cand_id_r);
      acc         = acc | match[i];
      ge_match[i] = acc;
      big[i]      = !valid[i] || (dist_r[i] > cand_dist_r);
      match_dist  = match_dist | (match[i] ? dist_r[i] : '0);
    end
  end

  assign shift_en = cmd.remove | cmd.emit;
  assign sh       = cmd.emit ? '1 : ge_match;
  assign ins_ok   = (count_r < keep_eff) || (|(valid & big));
  assign ins_en   = cmd.insert & ins_ok;

  // each entry either takes its upper neighbour (remove/emit) or, on insert,
  // its lower neighbour or the candidate
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_entry
    logic [ID_W-1:0]   hi_id;
    logic [DIST_W-1:0] hi_dist;
    logic [ID_W-1:0]   ins_id;
    logic [DIST_W-1:0] ins_dist;

    if (g == LIST_DEPTH - 1) begin : g_top
      assign hi_id   = id_r[g];
      assign hi_dist = dist_r[g];
    end else begin : g_mid
      assign hi_id   = id_r[g+1];
      assign hi_dist = dist_r[g+1];
    end

    if (g == 0) begin : g_first
      assign ins_id   = cand_id_r;
      assign ins_dist = cand_dist_r;
    end else begin : g_rest
      assign ins_id   = big[g-1] ? id_r[g-1]   : cand_id_r;
      assign ins_dist = big[g-1] ? dist_r[g-1] : cand_dist_r;
    end

    always_ff @(posedge clk) begin
      if (shift_en && sh[g]) begin
        id_r[g]   <= hi_id;
        dist_r[g] <= hi_dist;
      end else if (ins_en && big[g]) begin
        id_r[g]   <= ins_id;
        dist_r[g] <= ins_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      keep_r       <= KEEP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_r <= cfg_wdata;
      end
      out_strobe_r <= cmd.emit;
      if (cmd.load) begin
        if (count_r > keep_eff) begin
          count_r <= keep_eff;
        end
      end else if (cmd.remove) begin
        count_r <= count_r - CW'(1);
      end else if (ins_en) begin
        if (count_r < keep_eff) begin
          count_r <= count_r + CW'(1);
        end
      end else if (cmd.emit) begin
        if (count_r != '0) begin
          count_r <= count_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_id_r   <= in_item.item_id;
      cand_dist_r <= in_item.distance;
      cand_last_r <= in_item.last;
    end
    if (cmd.emit) begin
      if (count_r == '0) begin
        out_item_r <= '{entry_id: '0, entry_distance: '0, valid_res: 1'b0,
                        end_of_list: 1'b1};
      end else begin
        out_item_r <= '{entry_id: id_r[0], entry_distance: dist_r[0],
                        valid_res: 1'b1, end_of_list: (count_r == CW'(1))};
      end
    end
  end

  assign sts.found       = |match;
  assign sts.lower       = cand_dist_r < match_dist;
  assign sts.last        = cand_last_r;
  assign sts.final_entry = count_r <= CW'(1);

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.final_entry |=> count_r == '0)
    else $error("list not cleared after final emit");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cmd.emit))
    else $error("result strobe without emit");

  a_insert_keep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> count_r <= $past(keep_eff))
    else $error("insert grew list beyond keep count");

endmodule

`default_nettype wire

// ----- src/tkmmd_ctrl.sv -----
// Controller FSM: sequences load, match, remove, insert and emit steps.
// Uses tkmmd_pkg command/status types.
`default_nettype none

module tkmmd_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  tkmmd_pkg::sts_t  sts,
  output tkmmd_pkg::cmd_t  cmd,
  output logic             busy
);
  import tkmmd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_REMOVE,
    S_INSERT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        if (!sts.found) begin
          state_nxt = S_INSERT;
        end else if (sts.lower) begin
          state_nxt = S_REMOVE;
        end else begin
          state_nxt = sts.last ? S_EMIT : S_IDLE;
        end
      end
      S_REMOVE: state_nxt = S_INSERT;
      S_INSERT: state_nxt = sts.last ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (sts.final_entry) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != S_IDLE;
    end
  end

  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.remove = state_r == S_REMOVE;
  assign cmd.insert = state_r == S_INSERT;
  assign cmd.emit   = state_r == S_EMIT;
  assign busy       = busy_r;

endmodule

`default_nettype wire

// ----- src/top_k_merge_min_distance.sv -----
// Top level of the top-k nearest-neighbour list merge.
// Instantiates tkmmd_ctrl and tkmmd_dp; types from tkmmd_pkg.
//
// Use: a candidate (in_item) is taken at a clock edge with start high and
// busy low. Busy then stays high, and no new candidate is taken, until it
// is merged and, if last, the list sent: a match step over all held entries,
// a remove step to take out a duplicate whose distance falls, an insert step
// to shift the list and place the candidate; the list is a row of registers
// compared in parallel. A candidate marked last is merged, then the list is
// sent as a run from the emit state, one transfer per cycle on out_item with
// out_strobe high for that cycle, each transfer registered; n held entries
// give n transfers (an empty list gives one transfer with valid_res low).
// end_of_list marks the final transfer; the list is then empty. The receiver
// cannot stall, so transfers are never held back. keep_count must be written
// through cfg_we/cfg_wdata while busy is low; the block does not enforce it.
// 0 acts as 1, values above LIST_DEPTH as LIST_DEPTH. Reset (rst_n low,
// synchronous) empties the list and sets keep_count to 32.
`default_nettype none

module top_k_merge_min_distance #(
  parameter int unsigned LIST_DEPTH = tkmmd_pkg::DEPTH_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  tkmmd_pkg::in_item_t          in_item,
  input  wire                          cfg_we,
  input  wire [tkmmd_pkg::KEEP_W-1:0]  cfg_wdata,
  output logic                         out_strobe,
  output tkmmd_pkg::out_item_t         out_item
);
  import tkmmd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tkmmd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tkmmd_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top_k_merge_min_distance.sv -----
// Testbench for top_k_merge_min_distance: a directed table, then random candidate lists.
// Transfers are checked against typed table rows or an in-bench model of the sorted list.
// Depends on tkmmd_pkg and the top_k_merge_min_distance RTL.
`timescale 1ns / 1ps

module tb_top_k_merge_min_distance;
  import tkmmd_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 150000;
  localparam int N_DIRECTED  = 24;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    bit                keep_row;
    logic [KEEP_W-1:0] keep_val;
    in_item_t          item;
    bit                typed;
    out_item_t         result;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              cfg_we = 1'b0;
  logic [KEEP_W-1:0] cfg_wdata = '0;
  logic              out_strobe;
  out_item_t         out_item;

  logic [ID_W-1:0]   list_ids [LIST_DEPTH];
  logic [DIST_W-1:0] list_dists [LIST_DEPTH];
  int                list_len = 0;
  logic [KEEP_W-1:0] keep_setting = KEEP_RESET;
  out_item_t         expected_entries [$];
  out_item_t         oldest_entry;
  int                mismatch_count = 0;
  int                cycle_count = 0;
  bit                gaps_on = 1'b1;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 6'd0, '{32'h0, 32'h0, 1'b1}, 1'b1, '{32'h0, 32'h0, 1'b1, 1'b1}},
    '{1'b0, 6'd0, '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1}, 1'b1,
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1}},
    '{1'b0, 6'd0, '{32'd5, 32'd100, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd5, 32'd200, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd5, 32'd50, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd7, 32'd50, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd9, 32'd10, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd7, 32'd5, 1'b1}, 1'b0, '0},
    '{1'b1, 6'd0, '0, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd1, 32'd300, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd2, 32'd200, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd3, 32'd400, 1'b1}, 1'b1, '{32'd2, 32'd200, 1'b1, 1'b1}},
    '{1'b1, 6'd3, '0, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd10, 32'd1, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd11, 32'd2, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd12, 32'd3, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd13, 32'd4, 1'b0}, 1'b0, '0},
    '{1'b1, 6'd1, '0, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd14, 32'd9, 1'b1}, 1'b0, '0},
    '{1'b1, 6'd63, '0, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd20, 32'h80000000, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd21, 32'h7FFFFFFF, 1'b0}, 1'b0, '0},
    '{1'b0, 6'd0, '{32'd20, 32'h0000FFFF, 1'b1}, 1'b0, '0},
    '{1'b1, 6'd32, '0, 1'b0, '0}
  };

  top_k_merge_min_distance DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always #2 clk = ~clk;

  // Merge one candidate into the model list; on last, queue the run if asked and empty it.
  function automatic void merge_candidate(input in_item_t cand, input bit push_results);
    int        keep_eff;
    int        hit;
    int        pos;
    int        newcount;
    bit        found;
    out_item_t res;
    keep_eff = (keep_setting == 0) ? 1 :
               (keep_setting > LIST_DEPTH) ? LIST_DEPTH : int'(keep_setting);
    if (list_len > keep_eff) list_len = keep_eff;
    found = 1'b0;
    hit = 0;
    for (int i = 0; i < list_len; i++) begin
      if (!found && list_ids[i] == cand.item_id) begin
        found = 1'b1;
        hit = i;
      end
    end
    if (!found || cand.distance < list_dists[hit]) begin
      if (found) begin
        for (int i = hit; i + 1 < list_len; i++) begin
          list_ids[i]   = list_ids[i + 1];
          list_dists[i] = list_dists[i + 1];
        end
        list_len--;
      end
      pos = 0;
      while (pos < list_len && list_dists[pos] <= cand.distance) pos++;
      if (pos < keep_eff) begin
        newcount = (list_len < keep_eff) ? list_len + 1 : keep_eff;
        for (int i = newcount - 1; i > pos; i--) begin
          list_ids[i]   = list_ids[i - 1];
          list_dists[i] = list_dists[i - 1];
        end
        list_ids[pos]   = cand.item_id;
        list_dists[pos] = cand.distance;
        list_len = newcount;
      end
    end
    if (cand.last) begin
      if (push_results) begin
        if (list_len == 0) begin
          res = '{'0, '0, 1'b0, 1'b1};
          expected_entries.push_back(res);
        end
        for (int i = 0; i < list_len; i++) begin
          res = '{list_ids[i], list_dists[i], 1'b1, (i + 1 == list_len)};
          expected_entries.push_back(res);
        end
      end
      list_len = 0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  // Called just after the rising edge of clk; returns once busy is low after the candidate is taken.
  task automatic send_candidate(input in_item_t cand, input bit typed, input out_item_t typed_res);
    if (gaps_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cand;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) expected_entries.push_back(typed_res);
    merge_candidate(cand, !typed);
  endtask

  task automatic set_keep(input logic [KEEP_W-1:0] val);
    start <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    keep_setting = val;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_entries.size() == 0) begin
        report_mismatch($sformatf("transfer with nothing expected, id %h", out_item.entry_id));
      end else begin
        oldest_entry = expected_entries.pop_front();
        if (out_item.entry_id !== oldest_entry.entry_id)
          report_mismatch($sformatf("entry_id %h, want %h",
                                    out_item.entry_id, oldest_entry.entry_id));
        if (out_item.entry_distance !== oldest_entry.entry_distance)
          report_mismatch($sformatf("entry_distance %h, want %h",
                                    out_item.entry_distance, oldest_entry.entry_distance));
        if (out_item.valid_res !== oldest_entry.valid_res)
          report_mismatch($sformatf("valid_res %b, want %b",
                                    out_item.valid_res, oldest_entry.valid_res));
        if (out_item.end_of_list !== oldest_entry.end_of_list)
          report_mismatch($sformatf("end_of_list %b, want %b",
                                    out_item.end_of_list, oldest_entry.end_of_list));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int              sent;
    int              lists_done;
    int              len;
    int              id_mode;
    int              dist_mode;
    bit              noisy;
    logic [ID_W-1:0] id_base;
    in_item_t        cand;
    sent = 0;
    lists_done = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].keep_row) set_keep(directed_rows[r].keep_val);
      else send_candidate(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);
    end

    while (sent < RANDOM_ITEMS) begin
      gaps_on = !(sent >= 150 && sent < 250);
      if (lists_done == 10) begin
        start <= 1'b0;
        while (expected_entries.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if ($urandom_range(99) < 20) begin
        case ($urandom_range(5))
          0: set_keep(6'd0);
          1: set_keep(6'd1);
          2: set_keep(6'd32);
          3: set_keep(KEEP_W'($urandom_range(63, 33)));
          default: set_keep(KEEP_W'($urandom_range(31, 2)));
        endcase
      end
      len       = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(40, 13);
      id_mode   = $urandom_range(2);
      dist_mode = $urandom_range(3);
      noisy     = ($urandom_range(9) == 0);
      id_base   = $urandom;
      for (int idx = 0; idx < len; idx++) begin
        if (idx > 0 && $urandom_range(99) < 4) set_keep(KEEP_W'($urandom_range(len, 1)));
        cand.item_id = (id_mode == 0) ? $urandom : id_base + $urandom_range(9);
        case (dist_mode)
          0: cand.distance = $urandom_range(15);
          1: cand.distance = 32'hFFFFFFF0 + $urandom_range(15);
          default: cand.distance = $urandom;
        endcase
        cand.last = (idx == len - 1) || (noisy && $urandom_range(7) == 0);
        send_candidate(cand, 1'b0, '0);
        sent++;
      end
      lists_done++;
    end

    start <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- top_k_merge_min_distance.f -----
src/tkmmd_pkg.sv
src/tkmmd_dp.sv
src/tkmmd_ctrl.sv
src/top_k_merge_min_distance.sv
tb/tb_top_k_merge_min_distance.sv
